FILE: design/rotated_box_largest_fit_top_defines.svh
// ----------------------------------------------------------------------------
// Rotated box fitter assertion macros
// Implication checks used by the fitter RTL, clocked on the rising edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ROTATED_BOX_LARGEST_FIT_TOP_DEFINES_SVH
`define ROTATED_BOX_LARGEST_FIT_TOP_DEFINES_SVH

// same-cycle implication
`define RBF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rbf assertion failed");

// next-cycle implication
`define RBF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rbf assertion failed");

`endif

FILE: design/rbf_pkg.sv
// ----------------------------------------------------------------------------
// Rotated box fitter package
// Field widths, status structs and helpers shared by the fitter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rbf_pkg;

   localparam int BOX_W      = 10;
   localparam int ORG_W      = 15;
   localparam int TRIG_W     = 16;
   localparam int POS_W      = 16;
   localparam int AXIS_W     = 25;
   localparam int AREA_W     = 2 * BOX_W;
   localparam int PROD_W     = TRIG_W + BOX_W;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 104;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   function automatic logic [TRIG_W-1:0] trig_mag(input logic signed [TRIG_W-1:0] v);
      trig_mag = v[TRIG_W-1] ? TRIG_W'(-v) : TRIG_W'(v);
   endfunction

endpackage

`default_nettype wire

FILE: design/rbf_search.sv
// ----------------------------------------------------------------------------
// Rotated box fitter search unit
// Walks widths and heights with running products and areas, one candidate
// per cycle through a shared add and compare datapath, keeping the best fit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rotated_box_largest_fit_top_defines.svh"

module rbf_search #(
   parameter int SIDE_MAX  = 1023,
   parameter int FRAC_BITS = 14
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [rbf_pkg::BOX_W-1:0]   box_width,
   input  wire logic [rbf_pkg::BOX_W-1:0]   box_height,
   input  wire logic [rbf_pkg::TRIG_W-1:0]  mag_s,
   input  wire logic [rbf_pkg::TRIG_W-1:0]  mag_c,
   output rbf_pkg::unit_stat_type           stat,
   output logic      [rbf_pkg::BOX_W-1:0]   fit_width,
   output logic      [rbf_pkg::BOX_W-1:0]   fit_height
);

   localparam int BW     = rbf_pkg::BOX_W;
   localparam int AW     = rbf_pkg::AREA_W;
   localparam int PW     = rbf_pkg::PROD_W;
   localparam int ROOM_W = (((BW + FRAC_BITS) > PW) ? (BW + FRAC_BITS) : PW) + 2;

   typedef enum logic [2:0] {
      SR_IDLE = 3'b001,
      SR_SCAN = 3'b010,
      SR_DONE = 3'b100
   } srch_state_type;

   srch_state_type            state_ff, state_in;
   logic [BW-1:0]             lim_ff, lim_in;
   logic [BW-1:0]             w_ff, w_in;
   logic [BW-1:0]             h_ff, h_in;
   logic [AW-1:0]             area_ff, area_in;
   logic [AW-1:0]             best_ff, best_in;
   logic [BW-1:0]             fw_ff, fw_in;
   logic [BW-1:0]             fh_ff, fh_in;
   logic signed [ROOM_W-1:0]  rw_ff, rw_in;
   logic signed [ROOM_W-1:0]  rh_ff, rh_in;
   logic [PW-1:0]             ah_ff, ah_in;
   logic [PW-1:0]             ch_ff, ch_in;

   logic [BW-1:0]             max_side;
   logic [BW-1:0]             lim;
   logic                      fit;

   always_comb begin
      max_side = (box_width > box_height) ? box_width : box_height;
      lim      = (int'(max_side) > SIDE_MAX) ? BW'(SIDE_MAX) : max_side;
      fit      = ($signed(ROOM_W'(ah_ff)) <= rw_ff) && ($signed(ROOM_W'(ch_ff)) <= rh_ff);

      state_in = state_ff;
      lim_in   = lim_ff;
      w_in     = w_ff;
      h_in     = h_ff;
      area_in  = area_ff;
      best_in  = best_ff;
      fw_in    = fw_ff;
      fh_in    = fh_ff;
      rw_in    = rw_ff;
      rh_in    = rh_ff;
      ah_in    = ah_ff;
      ch_in    = ch_ff;

      unique case (state_ff)
         SR_IDLE: begin
            if (start) begin
               lim_in   = lim;
               w_in     = BW'(1);
               h_in     = BW'(1);
               area_in  = AW'(1);
               best_in  = '0;
               fw_in    = box_width;
               fh_in    = box_height;
               rw_in    = $signed(ROOM_W'(box_width) << FRAC_BITS) - $signed(ROOM_W'(mag_c));
               rh_in    = $signed(ROOM_W'(box_height) << FRAC_BITS) - $signed(ROOM_W'(mag_s));
               ah_in    = PW'(mag_s);
               ch_in    = PW'(mag_c);
               state_in = (lim == '0) ? SR_DONE : SR_SCAN;
            end
         end
         SR_SCAN: begin
            if (fit && (area_ff > best_ff)) begin
               best_in = area_ff;
               fw_in   = w_ff;
               fh_in   = h_ff;
            end
            if (fit && (h_ff != lim_ff)) begin
               h_in    = h_ff + BW'(1);
               ah_in   = ah_ff + PW'(mag_s);
               ch_in   = ch_ff + PW'(mag_c);
               area_in = area_ff + AW'(w_ff);
            end else if ((!fit && (h_ff == BW'(1))) || (w_ff == lim_ff)) begin
               // rooms only shrink with width: a failing first height ends the search
               state_in = SR_DONE;
            end else begin
               w_in    = w_ff + BW'(1);
               h_in    = BW'(1);
               rw_in   = rw_ff - $signed(ROOM_W'(mag_c));
               rh_in   = rh_ff - $signed(ROOM_W'(mag_s));
               ah_in   = PW'(mag_s);
               ch_in   = PW'(mag_c);
               area_in = AW'(w_ff) + AW'(1);
            end
         end
         SR_DONE: begin
            state_in = SR_IDLE;
         end
         default: begin
            state_in = SR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      lim_ff  <= lim_in;
      w_ff    <= w_in;
      h_ff    <= h_in;
      area_ff <= area_in;
      best_ff <= best_in;
      fw_ff   <= fw_in;
      fh_ff   <= fh_in;
      rw_ff   <= rw_in;
      rh_ff   <= rh_in;
      ah_ff   <= ah_in;
      ch_ff   <= ch_in;
   end

   assign stat.busy  = (state_ff != SR_IDLE);
   assign stat.done  = (state_ff == SR_DONE);
   assign fit_width  = fw_ff;
   assign fit_height = fh_ff;

   `RBF_ASSERT_IMP(a_scan_bounds, clock, reset, state_ff == SR_SCAN, (h_ff != '0) && (h_ff <= lim_ff) && (w_ff != '0) && (w_ff <= lim_ff))
   `RBF_ASSERT_NEXT(a_best_grows, clock, reset, state_ff == SR_SCAN, best_ff >= $past(best_ff))

endmodule

`default_nettype wire

FILE: design/rbf_place.sv
// ----------------------------------------------------------------------------
// Rotated box fitter placement unit
// One shared multiplier forms the four side products in turn; a short
// sequence then centers, shifts and saturates the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module rbf_place #(
   parameter int FRAC_BITS = 14
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic        [rbf_pkg::BOX_W-1:0]  fit_width,
   input  wire logic        [rbf_pkg::BOX_W-1:0]  fit_height,
   input  wire logic        [rbf_pkg::BOX_W-1:0]  box_width,
   input  wire logic        [rbf_pkg::BOX_W-1:0]  box_height,
   input  wire logic signed [rbf_pkg::ORG_W-1:0]  origin_x,
   input  wire logic signed [rbf_pkg::ORG_W-1:0]  origin_y,
   input  wire logic signed [rbf_pkg::TRIG_W-1:0] sine_q14,
   input  wire logic signed [rbf_pkg::TRIG_W-1:0] cosine_q14,
   input  wire logic        [rbf_pkg::TRIG_W-1:0] mag_s,
   input  wire logic        [rbf_pkg::TRIG_W-1:0] mag_c,
   output rbf_pkg::unit_stat_type                 stat,
   output logic             [rbf_pkg::POS_W-1:0]  placed_x,
   output logic             [rbf_pkg::POS_W-1:0]  placed_y,
   output logic             [rbf_pkg::AXIS_W-1:0] axis_x,
   output logic             [rbf_pkg::AXIS_W-1:0] axis_y
);

   localparam int TW  = rbf_pkg::TRIG_W;
   localparam int PW  = rbf_pkg::PROD_W;
   localparam int AXW = rbf_pkg::AXIS_W;
   localparam int PSW = rbf_pkg::POS_W;
   localparam int XW  = 22;
   localparam int VW  = XW + FRAC_BITS + 1;
   localparam logic [VW-1:0] FRAC_MASK = VW'((1 << FRAC_BITS) - 1);

   // product slots
   localparam logic [1:0] PRD_SH = 2'd0;
   localparam logic [1:0] PRD_CW = 2'd1;
   localparam logic [1:0] PRD_CH = 2'd2;
   localparam logic [1:0] PRD_SW = 2'd3;

   typedef enum logic [5:0] {
      PL_IDLE   = 6'b000001,
      PL_MUL    = 6'b000010,
      PL_CENTER = 6'b000100,
      PL_ROT_S  = 6'b001000,
      PL_ROT_C  = 6'b010000,
      PL_DONE   = 6'b100000
   } plc_state_type;

   plc_state_type          state_ff, state_in;
   logic [1:0]             step_ff, step_in;
   logic [PW-1:0]          prod_ff [4];
   logic signed [XW-1:0]   x_ff, x_in;
   logic signed [XW-1:0]   y_ff, y_in;
   logic [AXW-1:0]         axis_x_ff, axis_x_in;
   logic [AXW-1:0]         axis_y_ff, axis_y_in;

   logic [TW-1:0]          op_a;
   logic [rbf_pkg::BOX_W-1:0] op_b;
   logic [PW-1:0]          prod;
   logic [PW:0]            sum_w, sum_h;
   logic signed [XW-1:0]   diff_w, diff_h;
   logic signed [XW-1:0]   half_w, half_h;

   function automatic logic signed [XW-1:0] add_trunc(input logic signed [XW-1:0] base,
                                                     input logic [PW-1:0] add);
      logic signed [VW-1:0] v;
      logic signed [VW-1:0] r;
      v = (VW'(base) <<< FRAC_BITS) + $signed(VW'(add));
      if (v[VW-1]) begin
         r = (v + $signed(FRAC_MASK)) >>> FRAC_BITS;
      end else begin
         r = v >>> FRAC_BITS;
      end
      add_trunc = XW'(r);
   endfunction

   function automatic logic [AXW-1:0] axis_sat(input logic neg, input logic [PW-1:0] mag);
      logic big;
      logic [AXW-1:0] r;
      big = |mag[PW-1:AXW-1];
      if (neg) begin
         r = big ? {1'b1, {(AXW-1){1'b0}}} : AXW'(PW'(0) - mag);
      end else begin
         r = big ? {1'b0, {(AXW-1){1'b1}}} : AXW'(mag);
      end
      axis_sat = r;
   endfunction

   always_comb begin
      unique case (step_ff)
         PRD_SH: begin
            op_a = mag_s;
            op_b = fit_height;
         end
         PRD_CW: begin
            op_a = mag_c;
            op_b = fit_width;
         end
         PRD_CH: begin
            op_a = mag_c;
            op_b = fit_height;
         end
         PRD_SW: begin
            op_a = mag_s;
            op_b = fit_width;
         end
         default: begin
            op_a = mag_s;
            op_b = fit_width;
         end
      endcase
      prod = PW'(op_a) * PW'(op_b);

      sum_w  = (PW+1)'(prod_ff[PRD_SH]) + (PW+1)'(prod_ff[PRD_CW]);
      sum_h  = (PW+1)'(prod_ff[PRD_CH]) + (PW+1)'(prod_ff[PRD_SW]);
      diff_w = $signed(XW'(box_width)) - $signed(XW'(sum_w >> FRAC_BITS));
      diff_h = $signed(XW'(box_height)) - $signed(XW'(sum_h >> FRAC_BITS));
      half_w = (diff_w + $signed(XW'(diff_w[XW-1]))) >>> 1;
      half_h = (diff_h + $signed(XW'(diff_h[XW-1]))) >>> 1;

      state_in  = state_ff;
      step_in   = step_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      axis_x_in = axis_x_ff;
      axis_y_in = axis_y_ff;

      unique case (state_ff)
         PL_IDLE: begin
            if (start) begin
               step_in  = PRD_SH;
               state_in = PL_MUL;
            end
         end
         PL_MUL: begin
            step_in = step_ff + 2'd1;
            if (step_ff == PRD_SW) begin
               state_in = PL_CENTER;
            end
         end
         PL_CENTER: begin
            x_in     = XW'(origin_x) + half_w;
            y_in     = XW'(origin_y) + half_h;
            state_in = PL_ROT_S;
         end
         PL_ROT_S: begin
            if (!sine_q14[TW-1] && (sine_q14 != '0)) begin
               x_in = add_trunc(x_ff, prod_ff[PRD_SH]);
            end else begin
               y_in = add_trunc(y_ff, prod_ff[PRD_SW]);
            end
            state_in = PL_ROT_C;
         end
         PL_ROT_C: begin
            if (cosine_q14[TW-1]) begin
               x_in = add_trunc(x_ff, prod_ff[PRD_CW]);
               y_in = add_trunc(y_ff, prod_ff[PRD_CH]);
            end
            axis_x_in = axis_sat(cosine_q14[TW-1], prod_ff[PRD_CW]);
            axis_y_in = axis_sat(sine_q14[TW-1], prod_ff[PRD_SW]);
            state_in  = PL_DONE;
         end
         PL_DONE: begin
            state_in = PL_IDLE;
         end
         default: begin
            state_in = PL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PL_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff   <= step_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      axis_x_ff <= axis_x_in;
      axis_y_ff <= axis_y_in;
      if (state_ff == PL_MUL) begin
         prod_ff[step_ff] <= prod;
      end
   end

   assign stat.busy = (state_ff != PL_IDLE);
   assign stat.done = (state_ff == PL_DONE);
   assign placed_x  = PSW'(x_ff);
   assign placed_y  = PSW'(y_ff);
   assign axis_x    = axis_x_ff;
   assign axis_y    = axis_y_ff;

endmodule

`default_nettype wire

FILE: design/rotated_box_largest_fit_top.sv
// ----------------------------------------------------------------------------
// Rotated box largest fit
// Finds the largest rectangle whose rotated bounding box fits a given box,
// then centers it and returns its placement and rotated width vector.
//
// Request channel req_*: one word per layout request, taken only while the
// block is idle. Response channel rsp_*: one word per request, held in an
// output register until taken.
// Order of work to rsp_tvalid: a start register, the search, a search done
// state, four products on one shared multiplier, three adder states and a
// placement done state. The search tests one candidate height per cycle,
// up to M heights for each of up to M widths, M = min(max(box_width,
// box_height), SIDE_MAX), and ends early once a width admits no height;
// with zero sine and cosine all sides fit. One request is in flight at a
// time: a new one is taken only after the last has left the placement unit.
// Reset clears the sequencers and the response valid; nothing else is kept.
// When the receiver stalls, a finished result waits in the placement unit
// behind the occupied output register and the block takes no new request.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rotated_box_largest_fit_top_defines.svh"

module rotated_box_largest_fit_top #(
   parameter int SIDE_MAX  = 1023,
   parameter int FRAC_BITS = 14
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // box_width[9:0], box_height[19:10], origin_x[34:20], origin_y[49:35],
   // sine_q14[65:50], cosine_q14[81:66], zero pad [87:82]
   input  wire logic [rbf_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // fit_width[9:0], fit_height[19:10], placed_x[35:20], placed_y[51:36],
   // axis_x[76:52], axis_y[101:77], zero pad [103:102]
   output logic      [rbf_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int BW  = rbf_pkg::BOX_W;
   localparam int OW  = rbf_pkg::ORG_W;
   localparam int TW  = rbf_pkg::TRIG_W;
   localparam int PSW = rbf_pkg::POS_W;
   localparam int AXW = rbf_pkg::AXIS_W;

   typedef enum logic [3:0] {
      TP_IDLE   = 4'b0001,
      TP_SEARCH = 4'b0010,
      TP_PLACE  = 4'b0100,
      TP_HOLD   = 4'b1000
   } top_state_type;

   top_state_type                 state_ff, state_in;
   logic                          srch_start_ff, srch_start_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rbf_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [BW-1:0]                 box_w_ff, box_h_ff;
   logic signed [OW-1:0]          org_x_ff, org_y_ff;
   logic signed [TW-1:0]          sine_ff, cos_ff;

   logic                          req_accept;
   logic                          load;
   logic [TW-1:0]                 mag_s, mag_c;
   rbf_pkg::unit_stat_type        srch_stat;
   rbf_pkg::unit_stat_type        plc_stat;
   logic [BW-1:0]                 fit_w, fit_h;
   logic [PSW-1:0]                placed_x, placed_y;
   logic [AXW-1:0]                axis_x, axis_y;

   assign req_tready = (state_ff == TP_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign mag_s      = rbf_pkg::trig_mag(sine_ff);
   assign mag_c      = rbf_pkg::trig_mag(cos_ff);

   rbf_search #(
      .SIDE_MAX  (SIDE_MAX),
      .FRAC_BITS (FRAC_BITS)
   ) u_search (
      .clock      (clock),
      .reset      (reset),
      .start      (srch_start_ff),
      .box_width  (box_w_ff),
      .box_height (box_h_ff),
      .mag_s      (mag_s),
      .mag_c      (mag_c),
      .stat       (srch_stat),
      .fit_width  (fit_w),
      .fit_height (fit_h)
   );

   rbf_place #(
      .FRAC_BITS (FRAC_BITS)
   ) u_place (
      .clock      (clock),
      .reset      (reset),
      .start      (srch_stat.done),
      .fit_width  (fit_w),
      .fit_height (fit_h),
      .box_width  (box_w_ff),
      .box_height (box_h_ff),
      .origin_x   (org_x_ff),
      .origin_y   (org_y_ff),
      .sine_q14   (sine_ff),
      .cosine_q14 (cos_ff),
      .mag_s      (mag_s),
      .mag_c      (mag_c),
      .stat       (plc_stat),
      .placed_x   (placed_x),
      .placed_y   (placed_y),
      .axis_x     (axis_x),
      .axis_y     (axis_y)
   );

   always_comb begin
      load = (((state_ff == TP_PLACE) && plc_stat.done) || (state_ff == TP_HOLD))
             && (!rsp_valid_ff || rsp_tready);

      state_in      = state_ff;
      srch_start_in = req_accept;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, axis_y, axis_x, placed_y, placed_x, fit_h, fit_w};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         TP_IDLE: begin
            if (req_accept) begin
               state_in = TP_SEARCH;
            end
         end
         TP_SEARCH: begin
            if (srch_stat.done) begin
               state_in = TP_PLACE;
            end
         end
         TP_PLACE: begin
            if (plc_stat.done) begin
               state_in = load ? TP_IDLE : TP_HOLD;
            end
         end
         TP_HOLD: begin
            if (load) begin
               state_in = TP_IDLE;
            end
         end
         default: begin
            state_in = TP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= TP_IDLE;
         srch_start_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         srch_start_ff <= srch_start_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      if (req_accept) begin
         box_w_ff <= req_tdata[9:0];
         box_h_ff <= req_tdata[19:10];
         org_x_ff <= req_tdata[34:20];
         org_y_ff <= req_tdata[49:35];
         sine_ff  <= req_tdata[65:50];
         cos_ff   <= req_tdata[81:66];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `RBF_ASSERT_IMP(a_hold_output_full, clock, reset, state_ff == TP_HOLD, rsp_valid_ff)
   `RBF_ASSERT_IMP(a_accept_units_idle, clock, reset, req_accept, !srch_stat.busy && !plc_stat.busy)

endmodule

`default_nettype wire

FILE: test/rotated_box_largest_fit_top_test.sv
// ----------------------------------------------------------------------------
// Rotated box largest fit testbench
// Sends layout requests as stream words and checks every response word
// against a literal or a local predictor of the search and placement. A short directed
// table covers empty boxes, no-fit boxes, full-scale trig values and every
// sign combination. Random requests follow, mostly small boxes with a few
// wide ones. The sender works in bursts and the receiver stalls at random,
// with one long receiver hold-off and one full drain on the sender side.
// ----------------------------------------------------------------------------
`default_nettype none

module rotated_box_largest_fit_top_test;

   localparam int     SIDE_MAX    = 1023;
   localparam int     FRAC_BITS   = 14;
   localparam int     REQ_W       = rbf_pkg::REQ_DATA_W;
   localparam longint FIXED_ONE   = 64'sd1 << FRAC_BITS;
   localparam longint AXIS_HI     = 64'sd16777215;
   localparam longint AXIS_LO     = -64'sd16777216;
   localparam int     DIR_ROWS    = 19;
   localparam int     RAND_ITEMS  = 100;
   localparam int     HOLD_CYCLES = 5000;

   typedef struct packed {
      logic signed [15:0] cosine_q14;
      logic signed [15:0] sine_q14;
      logic signed [14:0] origin_y;
      logic signed [14:0] origin_x;
      logic        [9:0]  box_height;
      logic        [9:0]  box_width;
   } box_req_type;

   typedef struct packed {
      logic signed [24:0] axis_y;
      logic signed [24:0] axis_x;
      logic signed [15:0] placed_y;
      logic signed [15:0] placed_x;
      logic        [9:0]  fit_height;
      logic        [9:0]  fit_width;
   } fit_rsp_type;

   typedef struct packed {
      box_req_type req;
      logic        has_lit;
      fit_rsp_type lit;
   } box_row_type;

   typedef enum logic [1:0] {RDY_ALWAYS, RDY_HALF, RDY_SPARSE} ready_mode_type;

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   // box_width, box_height, origin_x, origin_y, sine_q14, cosine_q14, pad
   logic [rbf_pkg::REQ_DATA_W-1:0]    req_tdata  = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   // fit_width, fit_height, placed_x, placed_y, axis_x, axis_y, pad
   logic [rbf_pkg::RSP_DATA_W-1:0]    rsp_tdata;

   box_row_type    box_rows [DIR_ROWS];
   fit_rsp_type    fit_pending [$];
   int             fit_errors = 0;
   int             burst_left = 0;
   logic           hold_start = 1'b0;
   logic           hold_done  = 1'b0;
   int             hold_left  = 0;
   ready_mode_type ready_mode = RDY_ALWAYS;
   int             mode_left  = 0;

   rotated_box_largest_fit_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic box_req_type mk_req(int bw, int bh, int ox, int oy, int s, int c);
      box_req_type r;
      r.box_width  = 10'(bw);
      r.box_height = 10'(bh);
      r.origin_x   = 15'(ox);
      r.origin_y   = 15'(oy);
      r.sine_q14   = 16'(s);
      r.cosine_q14 = 16'(c);
      return r;
   endfunction

   function automatic fit_rsp_type mk_fit(int w, int h, int x, int y, int ax, int ay);
      fit_rsp_type f;
      f.fit_width  = 10'(w);
      f.fit_height = 10'(h);
      f.placed_x   = 16'(x);
      f.placed_y   = 16'(y);
      f.axis_x     = 25'(ax);
      f.axis_y     = 25'(ay);
      return f;
   endfunction

   // largest height in 1..lim with step*h <= room, 0 if none
   function automatic longint height_cap(longint step, longint room, longint lim);
      if (room < 0) return 0;
      if (step == 0) return lim;
      return (room / step < lim) ? room / step : lim;
   endfunction

   function automatic longint shift_trunc(longint base, longint add);
      return (base * FIXED_ONE + add) / FIXED_ONE;
   endfunction

   function automatic longint sat_axis(longint v);
      if (v > AXIS_HI) return AXIS_HI;
      if (v < AXIS_LO) return AXIS_LO;
      return v;
   endfunction

   function automatic fit_rsp_type predict_fit(box_req_type r);
      longint      bw, bh, ox, oy, s, c, as, ac, lim;
      longint      w, h1, h2, hm, best, fw, fh, ext_w, ext_h, x, y, ax, ay;
      fit_rsp_type p;
      bw  = longint'(r.box_width);
      bh  = longint'(r.box_height);
      ox  = longint'(r.origin_x);
      oy  = longint'(r.origin_y);
      s   = longint'(r.sine_q14);
      c   = longint'(r.cosine_q14);
      as  = (s < 0) ? -s : s;
      ac  = (c < 0) ? -c : c;
      lim = (bw > bh) ? bw : bh;
      if (lim > SIDE_MAX) lim = SIDE_MAX;
      best = 0;
      fw   = bw;
      fh   = bh;
      for (w = 1; w <= lim; w++) begin
         h1 = height_cap(as, bw * FIXED_ONE - ac * w, lim);
         h2 = height_cap(ac, bh * FIXED_ONE - as * w, lim);
         hm = (h1 < h2) ? h1 : h2;
         // strict compare: smaller width wins on equal area
         if (hm >= 1 && w * hm > best) begin
            best = w * hm;
            fw   = w;
            fh   = hm;
         end
      end
      ext_w = (as * fh + ac * fw) >>> FRAC_BITS;
      ext_h = (ac * fh + as * fw) >>> FRAC_BITS;
      x = ox + (bw - ext_w) / 2;
      y = oy + (bh - ext_h) / 2;
      if (s > 0) x = shift_trunc(x, s * fh);
      else       y = shift_trunc(y, -s * fw);
      if (c < 0) begin
         x = shift_trunc(x, -c * fw);
         y = shift_trunc(y, -c * fh);
      end
      ax = sat_axis(fw * c);
      ay = sat_axis(fw * s);
      p.fit_width  = fw[9:0];
      p.fit_height = fh[9:0];
      p.placed_x   = x[15:0];
      p.placed_y   = y[15:0];
      p.axis_x     = ax[24:0];
      p.axis_y     = ay[24:0];
      return p;
   endfunction

   function automatic int pick_trig();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return 16384;
         2:       return -16384;
         default: return int'($urandom_range(0, 32768)) - 16384;
      endcase
   endfunction

   function automatic int wide_trig();
      int mag;
      mag = $urandom_range(8192, 16384);
      return $urandom_range(0, 1) ? mag : -mag;
   endfunction

   // wide boxes keep one side small and both trig magnitudes large so the
   // search stops after a few dozen widths
   function automatic box_req_type random_box();
      int          big, little;
      box_req_type r;
      r.origin_x = 15'($urandom_range(0, 32767));
      r.origin_y = 15'($urandom_range(0, 32767));
      if ($urandom_range(0, 99) < 8) begin
         big    = $urandom_range(0, 3) == 0 ? 1023 : $urandom_range(0, 1023);
         little = $urandom_range(0, 15);
         if ($urandom_range(0, 1)) begin
            r.box_width  = 10'(big);
            r.box_height = 10'(little);
         end else begin
            r.box_width  = 10'(little);
            r.box_height = 10'(big);
         end
         r.sine_q14   = 16'(wide_trig());
         r.cosine_q14 = 16'(wide_trig());
      end else begin
         r.box_width  = 10'($urandom_range(0, 31));
         r.box_height = 10'($urandom_range(0, 31));
         r.sine_q14   = 16'(pick_trig());
         r.cosine_q14 = 16'(pick_trig());
      end
      return r;
   endfunction

   task automatic send_box(input box_req_type item, input logic has_lit,
                           input fit_rsp_type lit);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(item);
      do @(posedge clock); while (!req_tready);
      if (has_lit) fit_pending.push_back(lit);
      else         fit_pending.push_back(predict_fit(item));
   endtask

   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1500) : $urandom_range(1, 8);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(0, 5);
      end
   endtask

   initial begin
      box_rows[0]  = '{mk_req(0, 0, -16384, 16383, 0, 16384), 1'b1,
                       mk_fit(0, 0, -16384, 16383, 0, 0)};
      box_rows[1]  = '{mk_req(0, 0, 16383, -16384, -16384, -16384), 1'b1,
                       mk_fit(0, 0, 16383, -16384, 0, 0)};
      box_rows[2]  = '{mk_req(1, 1, 0, 0, 0, 16384), 1'b1,
                       mk_fit(1, 1, 0, 0, 16384, 0)};
      box_rows[3]  = '{mk_req(1, 1, 0, 0, 16384, 16384), 1'b1,
                       mk_fit(1, 1, 1, 0, 16384, 16384)};
      // nothing fits
      box_rows[4]  = '{mk_req(1023, 1, 0, 0, 16384, 16384), 1'b0, '0};
      box_rows[5]  = '{mk_req(1, 1023, -16384, -16384, -16384, -16384), 1'b0, '0};
      // one side empty
      box_rows[6]  = '{mk_req(0, 5, 100, -100, 0, 16384), 1'b0, '0};
      box_rows[7]  = '{mk_req(5, 0, -100, 100, 0, 16384), 1'b0, '0};
      box_rows[8]  = '{mk_req(1023, 3, 16383, 16383, 16384, 4096), 1'b0, '0};
      box_rows[9]  = '{mk_req(3, 1023, -16384, -16384, -4096, -16384), 1'b0, '0};
      box_rows[10] = '{mk_req(9, 5, 0, 0, 0, 0), 1'b0, '0};
      box_rows[11] = '{mk_req(16, 12, 1000, -1000, 11585, 11585), 1'b0, '0};
      box_rows[12] = '{mk_req(16, 12, -1000, 1000, 11585, -11585), 1'b0, '0};
      box_rows[13] = '{mk_req(16, 12, -5, 5, -11585, 11585), 1'b0, '0};
      box_rows[14] = '{mk_req(16, 12, 7, -7, -11585, -11585), 1'b0, '0};
      box_rows[15] = '{mk_req(31, 31, -16384, 16383, 16384, 0), 1'b0, '0};
      box_rows[16] = '{mk_req(31, 31, 16383, -16384, 0, -16384), 1'b0, '0};
      box_rows[17] = '{mk_req(20, 9, 1, -1, 6270, 15137), 1'b0, '0};
      box_rows[18] = '{mk_req(9, 20, -1, 1, -15137, 6270), 1'b0, '0};
   end

   initial begin
      int i;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (i = 0; i < DIR_ROWS; i++) begin
         send_box(box_rows[i].req, box_rows[i].has_lit, box_rows[i].lit);
         pace_sender();
      end
      for (i = 0; i < RAND_ITEMS; i++) begin
         if (i == 30) hold_start <= 1'b1;
         if (i == 60) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (fit_pending.size() != 0);
         end
         send_box(random_box(), 1'b0, '0);
         pace_sender();
      end
      req_tvalid <= 1'b0;
      do @(posedge clock); while (fit_pending.size() != 0);
      repeat (20) @(posedge clock);
      if (fit_errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         mode_left  <= 0;
         hold_left  <= 0;
         hold_done  <= 1'b0;
      end else if (hold_start && !hold_done) begin
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode <= ready_mode_type'($urandom_range(0, 2));
            mode_left  <= $urandom_range(16, 256);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (ready_mode)
            RDY_ALWAYS: rsp_tready <= 1'b1;
            RDY_HALF:   rsp_tready <= 1'($urandom_range(0, 1));
            default:    rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin : rsp_check
      fit_rsp_type got;
      fit_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[101:0];
         if (fit_pending.size() == 0) begin
            if (fit_errors < 10)
               $display("unexpected word: w=%0d h=%0d x=%0d y=%0d ax=%0d ay=%0d",
                        got.fit_width, got.fit_height, got.placed_x, got.placed_y,
                        got.axis_x, got.axis_y);
            fit_errors++;
         end else begin
            want = fit_pending.pop_front();
            if (got.fit_width !== want.fit_width || got.fit_height !== want.fit_height ||
                got.placed_x !== want.placed_x || got.placed_y !== want.placed_y ||
                got.axis_x !== want.axis_x || got.axis_y !== want.axis_y) begin
               if (fit_errors < 10) begin
                  $display("mismatch exp: w=%0d h=%0d x=%0d y=%0d ax=%0d ay=%0d",
                           want.fit_width, want.fit_height, want.placed_x, want.placed_y,
                           want.axis_x, want.axis_y);
                  $display("         got: w=%0d h=%0d x=%0d y=%0d ax=%0d ay=%0d",
                           got.fit_width, got.fit_height, got.placed_x, got.placed_y,
                           got.axis_x, got.axis_y);
               end
               fit_errors++;
            end
         end
      end
   end

   initial begin
      #30_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
